// ===== hw/rtl/lrtm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the linear recurrence term block.
// No dependencies; imported by every module of the block.
package lrtm_pkg;

    localparam int WORD_W     = 31;
    localparam int INDEX_BITS = 63;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam int ADDR_W     = 3;

    localparam logic [WORD_W-1:0] MOD_RESET  = WORD_W'(1000000007);
    localparam logic [WORD_W-1:0] MULT_RESET = WORD_W'(3);

    // register index as taken from paddr[2]
    localparam logic REG_MODULUS    = 1'b0;
    localparam logic REG_MULTIPLIER = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [INDEX_BITS-1:0] index_t;

    // 2x2 matrix, entry {row, col}
    typedef logic [3:0][WORD_W-1:0] mat_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t addend;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

    typedef enum logic [2:0] {
        MM_IDLE = 3'b001,
        MM_BITS = 3'b010,
        MM_ADD  = 3'b100
    } mm_state_t;

    typedef enum logic [4:0] {
        SQ_IDLE = 5'b00001,
        SQ_CRED = 5'b00010,
        SQ_PICK = 5'b00100,
        SQ_WAIT = 5'b01000,
        SQ_FIN  = 5'b10000
    } seq_state_t;

endpackage

// ===== hw/rtl/lrtm_mulmod.sv =====
`timescale 1ns / 1ps
// Shared modular multiply-add unit: (a*b + addend) mod m, one bit of b a cycle.
// Depends on lrtm_pkg. Needs a, addend below m.
module lrtm_mulmod
    import lrtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    input  word_t   modulus,
    output mm_rsp_t rsp
);

    mm_state_t        state_reg, state_next;
    word_t            acc_reg, acc_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            add_reg, add_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    word_t            res_reg, res_next;

    logic [WORD_W:0] m_ext;
    logic [WORD_W:0] dbl;
    logic [WORD_W:0] dbl_red;
    logic [WORD_W:0] sum;
    logic [WORD_W:0] sum_red;
    logic [WORD_W:0] fin;
    logic [WORD_W:0] fin_red;

    always_comb
    begin
        m_ext   = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (b_reg[WORD_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
        fin     = {1'b0, acc_reg} + {1'b0, add_reg};
        fin_red = (fin >= m_ext) ? fin - m_ext : fin;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        add_next   = add_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    add_next   = req.addend;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(WORD_W - 1);
                    state_next = MM_BITS;
                end
            end
            MM_BITS:
            begin
                acc_next = sum_red[WORD_W-1:0];
                b_next   = {b_reg[WORD_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = MM_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MM_ADD:
            begin
                res_next   = fin_red[WORD_W-1:0];
                done_next  = 1'b1;
                state_next = MM_IDLE;
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        add_reg <= add_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== hw/rtl/lrtm_seq.sv =====
`timescale 1ns / 1ps
// Square-and-multiply sequencer: holds the running and power matrices and
// walks the index bits, issuing each modular product to lrtm_mulmod. Uses lrtm_pkg.
module lrtm_seq
    import lrtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  index_t  n,
    input  word_t   modulus,
    input  word_t   multiplier,
    input  logic    res_ready,
    output logic    idle,
    output logic    res_valid,
    output word_t   res_value,
    output mm_req_t mm_req,
    input  mm_rsp_t mm_rsp
);

    seq_state_t state_reg, state_next;
    index_t     n_reg, n_next;
    mat_t       acc_reg, acc_next;
    mat_t       x_reg, x_next;
    mat_t       t_reg, t_next;
    logic [2:0] step_reg, step_next;
    logic       sq_reg, sq_next;
    word_t      val_reg, val_next;
    mm_req_t    req_reg, req_next;
    word_t      one_w;

    // step = {row, col, k}: r[row][col] = p[row][0]*x[0][col] + p[row][1]*x[1][col]
    function automatic mm_req_t make_req(logic [2:0] s, logic sq, mat_t acc, mat_t x,
                                         word_t addend);
        mm_req_t r;
        logic [1:0] pi;
        logic [1:0] qi;
        pi       = {s[2], s[0]};
        qi       = {s[0], s[1]};
        r.start  = 1'b1;
        r.a      = sq ? x[pi] : acc[pi];
        r.b      = x[qi];
        r.addend = addend;
        return r;
    endfunction

    always_comb
    begin
        one_w      = (modulus == WORD_W'(1)) ? '0 : WORD_W'(1);
        state_next = state_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        step_next  = step_reg;
        sq_next    = sq_reg;
        val_next   = val_reg;
        req_next   = req_reg;
        req_next.start = 1'b0;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    n_next = n;
                    if (n[INDEX_BITS-1:1] == '0)
                    begin
                        val_next   = {{(WORD_W-1){1'b0}}, n[0]};
                        state_next = SQ_FIN;
                    end
                    else if (modulus == '0)
                    begin
                        val_next   = '0;
                        state_next = SQ_FIN;
                    end
                    else
                    begin
                        // reduce c modulo m first
                        req_next   = '{start: 1'b1, a: one_w, b: multiplier, addend: '0};
                        state_next = SQ_CRED;
                    end
                end
            end
            SQ_CRED:
            begin
                if (mm_rsp.done)
                begin
                    x_next     = {WORD_W'(0), one_w, one_w, mm_rsp.result};
                    acc_next   = {one_w, WORD_W'(0), WORD_W'(0), one_w};
                    state_next = SQ_PICK;
                end
            end
            SQ_PICK:
            begin
                if (n_reg == '0)
                begin
                    val_next   = acc_reg[2];
                    state_next = SQ_FIN;
                end
                else
                begin
                    sq_next    = !n_reg[0];
                    step_next  = '0;
                    req_next   = make_req(3'd0, !n_reg[0], acc_reg, x_reg, '0);
                    state_next = SQ_WAIT;
                end
            end
            SQ_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    if (step_reg[0])
                    begin
                        t_next[step_reg[2:1]] = mm_rsp.result;
                    end
                    if (step_reg == 3'd7)
                    begin
                        if (sq_reg)
                        begin
                            x_next = t_next;
                            n_next = n_reg >> 1;
                        end
                        else
                        begin
                            acc_next = t_next;
                            n_next   = {n_reg[INDEX_BITS-1:1], 1'b0};
                        end
                        state_next = SQ_PICK;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                        req_next  = make_req(step_reg + 3'd1, sq_reg, acc_reg, x_reg,
                                             step_reg[0] ? '0 : mm_rsp.result);
                    end
                end
            end
            SQ_FIN:
            begin
                if (res_ready)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        t_reg    <= t_next;
        step_reg <= step_next;
        sq_reg   <= sq_next;
        val_reg  <= val_next;
    end

    assign idle      = (state_reg == SQ_IDLE);
    assign res_valid = (state_reg == SQ_FIN);
    assign res_value = val_reg;
    assign mm_req    = req_reg;

endmodule

// ===== hw/rtl/linear_recurrence_term_mod.sv =====
`timescale 1ns / 1ps
// Top level: stream ports, register port, output register and assertions.
// Depends on lrtm_pkg, lrtm_seq and lrtm_mulmod.

// Returns term n of g(n) = c*g(n-1) + g(n-2), g(0)=0, g(1)=1, modulo the
// modulus register, by raising [[c,1],[1,0]] to the n-th power with
// square-and-multiply. One item at a time: indices 0 and 1, or a zero
// modulus, finish without any modular product. Otherwise every modular
// product runs on one shared bit-serial multiply-add unit; an item takes
// one product to reduce c, then eight per squaring and per multiply step.
// A finished result waits in the output register while the next item is
// taken. Registers: modulus at 0x0, multiplier at 0x4; write only while no
// item is in flight.
module linear_recurrence_term_mod
    import lrtm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // [62:0] term_index
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [30:0] term_value
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    word_t   modulus_reg, modulus_next;
    word_t   multiplier_reg, multiplier_next;
    logic    out_valid_reg, out_valid_next;
    word_t   out_data_reg, out_data_next;
    logic    cfg_wr;
    logic    seq_idle;
    logic    res_valid;
    logic    res_ready;
    word_t   res_value;
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {1'b0, (paddr[2] == REG_MULTIPLIER) ? multiplier_reg : modulus_reg};

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = seq_idle;

    always_comb
    begin
        modulus_next    = modulus_reg;
        multiplier_next = multiplier_reg;
        if (cfg_wr && paddr[2] == REG_MODULUS)
        begin
            modulus_next = pwdata[WORD_W-1:0];
        end
        if (cfg_wr && paddr[2] == REG_MULTIPLIER)
        begin
            multiplier_next = pwdata[WORD_W-1:0];
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= MOD_RESET;
            multiplier_reg <= MULT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            modulus_reg    <= modulus_next;
            multiplier_reg <= multiplier_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    lrtm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_axis_tvalid && s_axis_tready),
        .n          (s_axis_tdata[INDEX_BITS-1:0]),
        .modulus    (modulus_reg),
        .multiplier (multiplier_reg),
        .res_ready  (res_ready),
        .idle       (seq_idle),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .mm_req     (mm_req),
        .mm_rsp     (mm_rsp)
    );

    lrtm_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .modulus (modulus_reg),
        .rsp     (mm_rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sequencer still idle after taking an item");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> m_axis_tvalid)
        else $error("finished result not loaded into output register");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && modulus_reg > WORD_W'(1) |-> out_data_reg < modulus_reg)
        else $error("result not reduced below modulus");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for linear_recurrence_term_mod: drives term indices on the
// input stream, predicts g(n) mod m by 2x2 matrix powering, checks the output stream.
// Depends on lrtm_pkg and the RTL of the block only.
module tb_top
    import lrtm_pkg::*;
();

    localparam logic [ADDR_W-1:0] ADDR_MODULUS    = ADDR_W'(4 * REG_MODULUS);
    localparam logic [ADDR_W-1:0] ADDR_MULTIPLIER = ADDR_W'(4 * REG_MULTIPLIER);

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of the registers
    logic [63:0] cur_modulus;
    logic [63:0] cur_multiplier;

    word_t terms_due[$];
    int    mismatches;
    int    items_sent;
    int    terms_seen;
    bit    calm;
    int    stall_ticket;

    linear_recurrence_term_mod u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // g(n) mod m via [[c,1],[1,0]]^n, every multiply and add reduced
    function automatic word_t term_mod(logic [63:0] n);
        logic [63:0] m;
        logic [63:0] acc[4];
        logic [63:0] x[4];
        logic [63:0] t[4];
        m = cur_modulus;
        if (n == 0)
            return '0;
        if (n == 1)
            return word_t'(1);
        if (m == 0)
            return '0;
        acc = '{1 % m, 0, 0, 1 % m};
        x   = '{cur_multiplier % m, 1 % m, 1 % m, 0};
        for (int b = 0; b < INDEX_BITS; b++)
        begin
            if (n[b])
            begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        t[2*i+j] = ((((acc[2*i] * x[j]) % m) + 0) % m
                                   + (acc[2*i+1] * x[2+j]) % m) % m;
                acc = t;
            end
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    t[2*i+j] = ((x[2*i] * x[j]) % m + (x[2*i+1] * x[2+j]) % m) % m;
            x = t;
        end
        return word_t'(acc[2]);
    endfunction

    // receiver: random stalls, calm stretches, and long hold-offs on request
    initial
    begin
        int hold_left;
        int seen_ticket;
        hold_left   = 0;
        seen_ticket = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_ticket != seen_ticket)
            begin
                seen_ticket = stall_ticket;
                hold_left   = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 16);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            terms_seen++;
            if (terms_due.size() == 0)
            begin
                $display("%0t: unexpected term_value %0d", $time, m_axis_tdata[30:0]);
                mismatches++;
            end
            else
            begin
                word_t want;
                want = terms_due.pop_front();
                if (m_axis_tdata[30:0] !== want)
                begin
                    $display("%0t: term_value expected %0d actual %0d",
                             $time, want, m_axis_tdata[30:0]);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_term(logic [63:0] n);
        if (!calm && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= n;
        do
            @(posedge clk);
        while (!s_axis_tready);
        terms_due.push_back(term_mod({1'b0, n[62:0]}));
        items_sent++;
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (terms_due.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODULUS)
            cur_modulus = value & 32'h7FFF_FFFF;
        else
            cur_multiplier = value & 32'h7FFF_FFFF;
    endtask

    task automatic set_regs(logic [31:0] m, logic [31:0] c);
        go_quiet();
        write_reg(ADDR_MODULUS, m);
        write_reg(ADDR_MULTIPLIER, c);
        @(posedge clk);
    endtask

    // reset values, index extremes, every index bit high and low
    task automatic test_directed();
        send_term(64'd0);
        send_term(64'd1);
        send_term(64'd2);
        send_term(64'd3);
        send_term(64'd10);
        send_term(64'h7FFF_FFFF_FFFF_FFFF);
        send_term(64'h4000_0000_0000_0000);
        send_term(64'h8000_0000_0000_0005);   // top padding bit must be ignored
        go_quiet();
    endtask

    // zero and unit modulus, zero and oversized multiplier, register extremes
    task automatic test_register_edges();
        set_regs(32'd0, 32'd5);
        send_term(64'd0);
        send_term(64'd1);
        send_term(64'd2);
        send_term(64'd7);
        set_regs(32'd1, 32'd3);
        send_term(64'd1);
        send_term(64'd6);
        set_regs(32'd2, 32'd0);
        send_term(64'd5);
        send_term(64'd12);
        set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_term(64'd9);
        send_term(64'd200);
        set_regs(32'd97, 32'hFFFF_FFFF);      // multiplier above modulus
        send_term(64'd4);
        send_term(64'd33);
        go_quiet();
    endtask

    // output held back while quick items pile up at the input
    task automatic test_backpressure();
        set_regs(32'd1000, 32'd7);
        stall_ticket++;
        for (int i = 0; i < 12; i++)
            send_term(64'($urandom_range(1)));
        go_quiet();
    endtask

    function automatic logic [63:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return {$urandom, $urandom};
        else if (r < 30)
            return 64'($urandom_range(15));
        else
            return 64'($urandom_range(255));
    endfunction

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++)
        begin
            logic [31:0] m;
            logic [31:0] c;
            m = (phase == 0) ? 32'h7FFF_FFFF : {1'b0, $urandom} % 32'h7FFF_FFFF + 2;
            c = (phase == 1) ? 32'd0 : $urandom;
            if (phase == 2)
                m = $urandom_range(2, 50);
            set_regs(m, c);
            for (int i = 0; i < 24; i++)
            begin
                calm = (phase == 3);
                send_term(pick_index());
            end
            calm = 1'b0;
        end
        go_quiet();
    endtask

    initial
    begin
        mismatches     = 0;
        items_sent     = 0;
        terms_seen     = 0;
        calm           = 1'b0;
        stall_ticket   = 0;
        cur_modulus    = MOD_RESET;
        cur_multiplier = MULT_RESET;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_edges();
        test_backpressure();
        test_random();

        repeat (100) @(posedge clk);
        $display("Sent %0d term indices, checked %0d terms over several modulus and", items_sent,
                 terms_seen);
        $display("multiplier settings, with random stalls and an output hold-off.");
        if (mismatches == 0 && terms_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
